/* rtl/core/pfat_pkg.sv */
// ----------------------------------------------------------------------------
// pfat_pkg
// Types and constants shared by the paging frame allocator and translator.
// ----------------------------------------------------------------------------
package pfat_pkg;

    localparam int DEF_MAX_FRAMES = 256;
    localparam int MAX_FRAME_SIZE = 4096;

    localparam int DIV_W  = 20;
    localparam int FS_W   = 13;
    localparam int FC_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_XLATE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  entry_index;
        logic [7:0]  frame_value;
        logic [19:0] process_size;
        logic [19:0] logical_address;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  first_page;
        logic [19:0] page_count;
        logic [7:0]  page_number;
        logic [11:0] word_offset;
        logic [7:0]  frame_number;
        logic [19:0] physical_address;
    } out_word_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [FS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [FS_W-1:0]  remainder;
    } div_rsp_t;

endpackage

/* rtl/core/pfat_divider.sv */
// ----------------------------------------------------------------------------
// pfat_divider
// Restoring divider, one quotient bit per cycle; done pulses after the last.
// ----------------------------------------------------------------------------
module pfat_divider import pfat_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] quo_reg;
    logic [FS_W-1:0]  rem_reg;
    logic [FS_W-1:0]  dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [FS_W:0]    shifted;
    logic [FS_W:0]    diff;
    logic             fits;
    logic [FS_W-1:0]  rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? diff[FS_W-1:0] : shifted[FS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* rtl/core/paging_frame_allocator_translator_core.sv */
// Sequence: load and unknown words go from S_IDLE straight to S_FINISH; allocate
// passes through S_DIVIDE, and translate through S_DIVIDE and S_MULTIPLY (S_DIVIDE
// only for a bad address). One word at a time, with m_ready high; the 20-step shared
// divider and the map read and multiply set how long each word takes.
// Reset (aresetn low, synchronous) clears the page pointer, the sequencer and the
// output valid, and restores frame_size 16 and frame_count 256; the map is not cleared.
// ----------------------------------------------------------------------------
// paging_frame_allocator_translator_core
// Frame map, linear page allocator and paged address translation.
// ----------------------------------------------------------------------------
module paging_frame_allocator_translator_core import pfat_pkg::*; #(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FS_W-1:0]      cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_word
);

    localparam int PW = $clog2(MAX_FRAMES + 1);
    localparam int AW = $clog2(MAX_FRAMES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_MULTIPLY,
        S_FINISH
    } state_t;

    state_t           state_reg;
    logic [1:0]       op_reg;
    logic [PW-1:0]    nfp_reg;
    logic [FS_W-1:0]  frame_size_reg;
    logic [FC_W-1:0]  frame_count_reg;
    out_word_t        res_reg;
    out_word_t        out_reg;
    logic             m_valid_reg;

    logic [7:0]       frame_map [MAX_FRAMES];
    logic [7:0]       rd_data_reg;

    logic [FS_W-1:0]  fs_eff;
    logic [PW-1:0]    fc_eff;
    logic [PW-1:0]    free_frames;
    logic             accept;
    logic             map_wr;
    logic             map_rd;
    logic             out_load;
    logic [20:0]      product;
    out_word_t        out_next;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    always_comb begin
        if (frame_size_reg == '0) begin
            fs_eff = FS_W'(1);
        end else if (32'(frame_size_reg) > MAX_FRAME_SIZE) begin
            fs_eff = FS_W'(MAX_FRAME_SIZE);
        end else begin
            fs_eff = frame_size_reg;
        end
        if (32'(frame_count_reg) > MAX_FRAMES) begin
            fc_eff = PW'(MAX_FRAMES);
        end else begin
            fc_eff = PW'(frame_count_reg);
        end
        free_frames = (fc_eff > nfp_reg) ? fc_eff - nfp_reg : '0;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign map_wr  = accept && (s_word.operation == OP_LOAD)
                     && (32'(s_word.entry_index) < MAX_FRAMES);
    assign map_rd  = (state_reg == S_DIVIDE) && div_rsp.done && (op_reg == OP_XLATE)
                     && (32'(div_rsp.quotient) < 32'(nfp_reg));
    assign out_load = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        div_req.start    = accept && ((s_word.operation == OP_ALLOC)
                                      || (s_word.operation == OP_XLATE));
        div_req.dividend = (s_word.operation == OP_ALLOC) ? s_word.process_size
                                                          : s_word.logical_address;
        div_req.divisor  = fs_eff;
    end

    pfat_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (map_wr) begin
            frame_map[AW'(s_word.entry_index)] <= s_word.frame_value;
        end
        if (map_rd) begin
            rd_data_reg <= frame_map[div_rsp.quotient[AW-1:0]];
        end
    end

    always_comb begin
        product  = rd_data_reg * fs_eff;
        out_next = res_reg;
        out_next.physical_address = res_reg.physical_address + 20'(res_reg.word_offset);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            nfp_reg         <= '0;
            frame_size_reg  <= FS_W'(16);
            frame_count_reg <= FC_W'(256);
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FRAME_SIZE:  frame_size_reg  <= cfg_wdata;
                    REG_FRAME_COUNT: frame_count_reg <= cfg_wdata[FC_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg  <= s_word.operation;
                        res_reg <= '0;
                        if (div_req.start) begin
                            state_reg <= S_DIVIDE;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_DIVIDE: begin
                    if (div_rsp.done) begin
                        if (op_reg == OP_ALLOC) begin
                            res_reg.first_page <= 9'(nfp_reg);
                            res_reg.page_count <= div_rsp.quotient;
                            if (32'(div_rsp.quotient) > 32'(free_frames)) begin
                                res_reg.status <= ST_NOFIT;
                            end else begin
                                res_reg.status <= ST_OK;
                                nfp_reg <= PW'(32'(nfp_reg) + 32'(div_rsp.quotient));
                            end
                            state_reg <= S_FINISH;
                        end else if (map_rd) begin
                            res_reg.status      <= ST_OK;
                            res_reg.page_number <= div_rsp.quotient[7:0];
                            res_reg.word_offset <= div_rsp.remainder[11:0];
                            state_reg <= S_MULTIPLY;
                        end else begin
                            res_reg.status <= ST_BADADDR;
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_MULTIPLY: begin
                    res_reg.frame_number     <= rd_data_reg;
                    res_reg.physical_address <= product[19:0];
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_load) begin
                        out_reg   <= out_next;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

endmodule
